/* hw/rtl/sphere_map_texel_store_assert.svh */
// Assertion macros shared by the checker of the sphere-map texel store.
`ifndef SPHERE_MAP_TEXEL_STORE_ASSERT_SVH
`define SPHERE_MAP_TEXEL_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define SMS_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sphere map texel store: property violated");

// Next-cycle implication, disabled while reset is low
`define SMS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sphere map texel store: property violated");

`endif

/* hw/rtl/sms_pkg.sv */
// Package of the sphere-map texel store: widths, row tables and lookup functions.
`default_nettype none

package sms_pkg;

  // Map geometry at a resolution of 64
  localparam int Resolution = 64;
  localparam int NumRows    = Resolution / 2;
  localparam int HalfRows   = Resolution / 4;
  localparam int RowBits    = $clog2(NumRows);
  localparam int LenBits    = $clog2(Resolution + 1);
  localparam int TexelCount = 1384;
  localparam int AddrBits   = $clog2(TexelCount);
  localparam int FracBits   = 16;
  localparam int DataBits   = 24;

  // Command codes of an input beat
  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  typedef logic [RowBits-1:0]  row_t;
  typedef logic [LenBits-1:0]  len_t;
  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [FracBits-1:0] frac_t;

  // Row lengths ceil(64*cos(2*pi*k/64)) from the equator outwards
  localparam len_t HalfLen [HalfRows] = '{
    64, 64, 63, 62, 60, 57, 54, 50, 46, 41, 36, 31, 25, 19, 13, 7
  };

  // Store index of the first texel of each row
  localparam addr_t RowStart [NumRows] = '{
       0,    7,   20,   39,   64,   95,  131,  172,
     218,  268,  322,  379,  439,  501,  564,  628,
     692,  756,  820,  883,  945, 1005, 1062, 1116,
    1166, 1212, 1253, 1289, 1320, 1345, 1364, 1377
  };

  // Length of a row, mirrored about the equator
  function automatic len_t row_length(input row_t row);
    row_t k;
    if (row >= row_t'(HalfRows)) begin
      k = row - row_t'(HalfRows);
    end else begin
      k = row_t'(HalfRows - 1) - row;
    end
    return HalfLen[k[RowBits-2:0]];
  endfunction

  // First store index of a row
  function automatic addr_t row_start(input row_t row);
    return RowStart[row];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sms_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sms_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write the addressed word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data, hold it between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sms_addr_map.sv */
// Coordinate to store-index mapping of the sphere-map texel store.
`default_nettype none

module sms_addr_map (
  input  wire logic [sms_pkg::FracBits-1:0] u_frac_i,
  input  wire logic [sms_pkg::FracBits-1:0] v_frac_i,
  output logic      [sms_pkg::AddrBits-1:0] addr_o
);

  localparam int FracW = sms_pkg::FracBits;
  localparam int LenW  = sms_pkg::LenBits;
  localparam int RowW  = sms_pkg::RowBits;

  sms_pkg::row_t              row;
  sms_pkg::len_t              len;
  logic [FracW+LenW-1:0]      prod;
  logic [LenW-1:0]            col;

  // Pick the latitude row from the top bits of v
  assign row = v_frac_i[FracW-1 -: RowW];

  // Scale u by the row length and add the row start
  always_comb begin
    len    = sms_pkg::row_length(row);
    prod   = (FracW + LenW)'(u_frac_i) * (FracW + LenW)'(len);
    col    = prod[FracW+LenW-1:FracW];
    addr_o = sms_pkg::row_start(row) + sms_pkg::AddrBits'(col);
  end

endmodule

`default_nettype wire

/* hw/rtl/sphere_map_texel_store.sv */
// Top level of the sphere-map texel store.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o | command, u_frac, v_frac, write_data
//   out     | output    | out_valid_o / out_stall_i | read_data, texel_address
//
// One beat is accepted per cycle while in_stall_o is low; a read's result passes through the
// registered read port of the texel RAM and then the output register.
// A write gives no result.
// After reset the RAM is cleared one word a cycle, all 1384 words; in_stall_o stays
// high until the pass ends.
// A stalled output holds one result while one more read waits on the RAM port; the
// input then stalls.
`default_nettype none

module sphere_map_texel_store #(
  parameter int TEXEL_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic [sms_pkg::FracBits-1:0]  u_frac_i,
  input  wire logic [sms_pkg::FracBits-1:0]  v_frac_i,
  input  wire logic [sms_pkg::DataBits-1:0]  write_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [sms_pkg::DataBits-1:0]  read_data_o,
  output logic      [sms_pkg::AddrBits-1:0]  texel_address_o
);

  localparam int DataW = sms_pkg::DataBits;
  localparam int AddrW = sms_pkg::AddrBits;

  logic             accept;
  logic             move;
  logic [AddrW-1:0] map_addr;

  logic             clear_q, clear_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [TEXEL_BITS-1:0] ram_wdata;
  logic             ram_re;
  logic [TEXEL_BITS-1:0] ram_rdata;

  logic             pend_q, pend_d;
  logic [AddrW-1:0] pend_addr_q;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q;
  logic [AddrW-1:0] out_addr_q;

  // Map coordinates to a store index
  sms_addr_map u_addr_map (
    .u_frac_i (u_frac_i),
    .v_frac_i (v_frac_i),
    .addr_o   (map_addr)
  );

  // Handshake: hold input while clearing or while a read result cannot advance
  assign move       = !out_valid_q || !out_stall_i;
  assign in_stall_o = clear_q || (pend_q && !move);
  assign accept     = in_valid_i && !in_stall_o;

  // Clearing pass after reset
  always_comb begin
    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (clear_q) begin
      clr_cnt_d = clr_cnt_q + AddrW'(1);
      if (clr_cnt_q == AddrW'(sms_pkg::TexelCount - 1)) begin
        clear_d = 1'b0;
      end
    end
  end

  // Drive the RAM ports from the clearing pass or from the accepted beat
  always_comb begin
    ram_we    = clear_q || (accept && command_i == sms_pkg::CmdWrite);
    ram_waddr = clear_q ? clr_cnt_q : map_addr;
    ram_wdata = clear_q ? '0 : TEXEL_BITS'(write_data_i);
    ram_re    = accept && command_i != sms_pkg::CmdWrite;
  end

  sms_ram #(
    .WIDTH (TEXEL_BITS),
    .DEPTH (sms_pkg::TexelCount)
  ) u_texel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (map_addr),
    .rdata_o (ram_rdata)
  );

  // Track a read whose data sits on the RAM output
  always_comb begin
    pend_d = pend_q;
    if (ram_re) begin
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
  end

  // Load the output register when a pending read can advance, drop on take
  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_q && move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q     <= 1'b1;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clear_q     <= clear_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      pend_addr_q <= map_addr;
    end
    if (pend_q && move) begin
      out_data_q <= DataW'(ram_rdata);
      out_addr_q <= pend_addr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_data_q;
  assign texel_address_o = out_addr_q;

endmodule

`default_nettype wire

/* hw/rtl/sms_checker.sv */
// Port-level checker of the sphere-map texel store and its bind.
`default_nettype none

`include "sphere_map_texel_store_assert.svh"

module sms_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          command_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [sms_pkg::DataBits-1:0]  read_data_o,
  input wire logic [sms_pkg::AddrBits-1:0]  texel_address_o
);

  localparam int AddrW = sms_pkg::AddrBits;

  logic out_held;
  logic read_taken;

  // Stalled result beat and accepted read beat
  assign out_held   = out_valid_o && out_stall_i;
  assign read_taken = in_valid_i && !in_stall_o && command_i == sms_pkg::CmdRead;

  // A stalled result beat stays
  `SMS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o)

  // A stalled result beat keeps its payload
  `SMS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_held, $stable({read_data_o, texel_address_o}))

  // Every result points inside the store
  `SMS_ASSERT_IMPLIES(a_addr_range, clk_i, rst_ni, out_valid_o, texel_address_o < AddrW'(1384))

  // An accepted read is followed by a valid output beat
  `SMS_ASSERT_IMPLIES(a_read_result, clk_i, rst_ni, $past(read_taken, 2), out_valid_o)

endmodule

bind sphere_map_texel_store sms_checker u_sms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .command_i       (command_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .read_data_o     (read_data_o),
  .texel_address_o (texel_address_o)
);

`default_nettype wire
